FILE: rtl/srmam_pkg.sv
`default_nettype none
package srmam_pkg;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int IN_VAL_W = 32;
  localparam int SUM_W   = 48;
  localparam int TERM_W  = 56;
  localparam int VEC_DEPTH = 64;
  localparam int OUT_MAX = 64;
  localparam int NUM_ROWS_W = 7;
  localparam int THR_W   = 31;

  localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) <<< (SUM_W - 1));
  localparam longint TERM_LIM = longint'(1) <<< 54;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_VEC     = 3'd1;
  localparam logic [2:0] MODE_MUL_ALL = 3'd2;
  localparam logic [2:0] MODE_ROW     = 3'd3;
  localparam logic [2:0] MODE_PRUNE   = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;

  localparam logic CFG_NUM_ROWS  = 1'b0;
  localparam logic CFG_PRUNE_THR = 1'b1;

  typedef struct packed {
    logic [2:0]                 mode;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic signed [IN_VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
    logic                    overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_START,
    DP_CNT_RD,
    DP_SCAN,
    DP_ADD_UPD,
    DP_ADD_NEW,
    DP_SUM,
    DP_EMIT,
    DP_PRUNE,
    DP_PRN_WB
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       add_ok;
    logic       m_zero;
    logic       scan_hit;
    logic       scan_end;
    logic       sum_done;
    logic       out_free;
    logic       emit_last;
    logic       prn_last;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/sparse_row_matrix_assemble_multiply.sv
`default_nettype none
// Channel | Ports                          | Beat
// input   | in_valid, in_ready, in_item    | one command (mode, row, col, value)
// result  | out_valid, out_ready, out_item | one row sum with last and overflow
// config  | cfg_we, cfg_index, cfg_wdata   | one register write, no wait
// One command at a time; it is accepted in S_IDLE and decoded in S_DECODE, where vector write and clear end.
// Add: a count read, then a scan of the row's stored columns, one entry memory read a cycle, then update or append.
// Row sum: a count read, then entry read, vector read, multiply and add, then an emit that waits on out_ready.
// Prune: all ROWS rows after decode, each a count read, a scan that compacts kept entries, and a count write-back.
// Synchronous reset empties every row and the vector through valid bits at once.
// A full output register holds the next row sum until out_ready.
module sparse_row_matrix_assemble_multiply #(
  parameter int ROWS            = 64,
  parameter int ENTRIES_PER_ROW = 16,
  parameter int VALUE_BITS      = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire srmam_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output srmam_pkg::out_item_t      out_item,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [30:0]          cfg_wdata
);

  srmam_pkg::dp_cmd_t cmd;
  srmam_pkg::dp_sts_t sts;

  srmam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srmam_dp #(
    .ROWS            (ROWS),
    .ENTRIES_PER_ROW (ENTRIES_PER_ROW),
    .VALUE_BITS      (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: rtl/srmam_ctrl.sv
`default_nettype none
module srmam_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire srmam_pkg::dp_sts_t sts,
  output srmam_pkg::dp_cmd_t     cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DECODE   = 11'b000_0000_0010,
    S_CNT      = 11'b000_0000_0100,
    S_ADD_SCAN = 11'b000_0000_1000,
    S_ADD_UPD  = 11'b000_0001_0000,
    S_ADD_NEW  = 11'b000_0010_0000,
    S_SUM_RUN  = 11'b000_0100_0000,
    S_EMIT     = 11'b000_1000_0000,
    S_PRN_RUN  = 11'b001_0000_0000,
    S_PRN_WB   = 11'b010_0000_0000,
    S_SPARE    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = srmam_pkg::DP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = srmam_pkg::DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op    = srmam_pkg::DP_START;
        state_nxt = S_IDLE;
        case (sts.mode)
          srmam_pkg::MODE_ADD:     state_nxt = sts.add_ok ? S_CNT : S_IDLE;
          srmam_pkg::MODE_MUL_ALL: state_nxt = sts.m_zero ? S_IDLE : S_CNT;
          srmam_pkg::MODE_ROW:     state_nxt = S_CNT;
          srmam_pkg::MODE_PRUNE:   state_nxt = S_CNT;
          default:                 state_nxt = S_IDLE;
        endcase
      end
      S_CNT: begin
        cmd.op = srmam_pkg::DP_CNT_RD;
        case (sts.mode)
          srmam_pkg::MODE_ADD:   state_nxt = S_ADD_SCAN;
          srmam_pkg::MODE_PRUNE: state_nxt = S_PRN_RUN;
          default:               state_nxt = S_SUM_RUN;
        endcase
      end
      S_ADD_SCAN: begin
        cmd.op = srmam_pkg::DP_SCAN;
        if (sts.scan_hit) begin
          state_nxt = S_ADD_UPD;
        end else if (sts.scan_end) begin
          state_nxt = S_ADD_NEW;
        end
      end
      S_ADD_UPD: begin
        cmd.op    = srmam_pkg::DP_ADD_UPD;
        state_nxt = S_IDLE;
      end
      S_ADD_NEW: begin
        cmd.op    = srmam_pkg::DP_ADD_NEW;
        state_nxt = S_IDLE;
      end
      S_SUM_RUN: begin
        cmd.op = srmam_pkg::DP_SUM;
        if (sts.sum_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = srmam_pkg::DP_EMIT;
          state_nxt = sts.emit_last ? S_IDLE : S_CNT;
        end
      end
      S_PRN_RUN: begin
        cmd.op = srmam_pkg::DP_PRUNE;
        if (sts.scan_end) begin
          state_nxt = S_PRN_WB;
        end
      end
      S_PRN_WB: begin
        cmd.op    = srmam_pkg::DP_PRN_WB;
        state_nxt = sts.prn_last ? S_IDLE : S_CNT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/srmam_dp.sv
`default_nettype none
module srmam_dp #(
  parameter int ROWS            = 64,
  parameter int ENTRIES_PER_ROW = 16,
  parameter int VALUE_BITS      = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire srmam_pkg::dp_cmd_t   cmd,
  output srmam_pkg::dp_sts_t        sts,
  input  wire srmam_pkg::in_item_t  in_item,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [30:0]          cfg_wdata,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output srmam_pkg::out_item_t      out_item
);

  localparam int RW  = $clog2(ROWS);
  localparam int KW  = $clog2(ENTRIES_PER_ROW + 1);
  localparam int ENT_DEPTH = ROWS * ENTRIES_PER_ROW;
  localparam int AW  = $clog2(ENT_DEPTH);
  localparam int EW  = ($clog2(ROWS + 1) > 7) ? $clog2(ROWS + 1) : 7;
  localparam int VB  = VALUE_BITS;
  localparam int VB1 = VALUE_BITS + 1;
  localparam int VW  = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int PW  = VALUE_BITS + 32;
  localparam int SW  = VALUE_BITS + 16;
  localparam int TW  = (SW > 56) ? SW : 56;
  localparam int ACW = 57 + KW;
  localparam int MW  = (VB1 > 31) ? VB1 : 31;
  localparam int CW  = srmam_pkg::COL_W;
  localparam int VAW = $clog2(srmam_pkg::VEC_DEPTH);

  localparam logic signed [VW-1:0]  VMAX = VW'((longint'(1) <<< (VALUE_BITS - 1)) - 1);
  localparam logic signed [VW-1:0]  VMIN = -VMAX - VW'(1);
  localparam logic signed [TW-1:0]  TPOS = TW'(srmam_pkg::TERM_LIM);
  localparam logic signed [TW-1:0]  TNEG = -TPOS;
  localparam logic signed [ACW-1:0] AMAX = ACW'(srmam_pkg::SUM_MAX);
  localparam logic signed [ACW-1:0] AMIN = ACW'(srmam_pkg::SUM_MIN);

  logic [CW-1:0]        ent_col_mem [ENT_DEPTH];
  logic signed [VB-1:0] ent_val_mem [ENT_DEPTH];
  logic [KW-1:0]        cnt_mem     [ROWS];
  logic signed [31:0]   vec_mem     [srmam_pkg::VEC_DEPTH];

  logic [ROWS-1:0]                 cnt_vld_r;
  logic [srmam_pkg::VEC_DEPTH-1:0] vec_vld_r;

  srmam_pkg::in_item_t  op_r;
  srmam_pkg::out_item_t out_item_r;
  logic                 out_valid_r;
  logic [RW-1:0]        cur_row_r;
  logic                 row_ok_r;
  logic [6:0]           num_rows_r;
  logic [30:0]          thr_r;
  logic                 dropped_r;
  logic [KW-1:0]        k_r, ek_r, keep_r;
  logic                 ev_r, pv1_r, pv2_r;
  logic signed [VB-1:0] val1_r;
  logic signed [PW-1:0] prod_r;
  logic signed [ACW-1:0] acc_r;

  logic [CW-1:0]        ent_col_q;
  logic signed [VB-1:0] ent_val_q;
  logic [KW-1:0]        cnt_mem_q;
  logic                 cnt_vld_q;
  logic signed [31:0]   vec_mem_q;
  logic                 vec_vld_q;

  logic [EW-1:0]         eff_n, m_cnt;
  logic [KW-1:0]         cnt;
  logic                  more, col_hit, ent_rd, ent_we, cnt_we, vec_we, full;
  logic [AW-1:0]         row_base, ent_raddr, ent_waddr;
  logic [CW-1:0]         ent_wcol;
  logic signed [VB-1:0]  ent_wval, sat_in, upd_val;
  logic [KW-1:0]         cnt_wdata;
  logic signed [VW-1:0]  vx;
  logic signed [VB1-1:0] upd_sum, mag;
  logic                  keep_ok;
  logic signed [31:0]    vec_data;
  logic signed [SW-1:0]  sh;
  logic signed [TW-1:0]  tx, tcl;
  logic signed [ACW-1:0] acc_sat;
  logic                  emit_last;

  assign eff_n = (EW'(num_rows_r) > EW'(ROWS)) ? EW'(ROWS) : EW'(num_rows_r);
  assign m_cnt = (eff_n > EW'(srmam_pkg::OUT_MAX)) ? EW'(srmam_pkg::OUT_MAX) : eff_n;
  assign cnt   = (cnt_vld_q && row_ok_r) ? cnt_mem_q : '0;
  assign full  = !(cnt < KW'(ENTRIES_PER_ROW));
  assign more  = k_r < cnt;
  assign col_hit = ev_r && (ent_col_q == op_r.col);
  assign row_base = AW'(cur_row_r) * AW'(ENTRIES_PER_ROW);
  assign ent_raddr = row_base + AW'(k_r);
  assign vec_data = vec_vld_q ? vec_mem_q : '0;

  assign vx = VW'(op_r.value);
  assign sat_in = (vx > VMAX) ? VB'(VMAX) : ((vx < VMIN) ? VB'(VMIN) : VB'(vx));
  assign upd_sum = VB1'(ent_val_q) + VB1'(sat_in);
  assign upd_val = (upd_sum > VB1'(VMAX)) ? VB'(VMAX) :
                   ((upd_sum < VB1'(VMIN)) ? VB'(VMIN) : VB'(upd_sum));

  assign mag = (ent_val_q < 0) ? -VB1'(ent_val_q) : VB1'(ent_val_q);
  assign keep_ok = $unsigned(MW'(mag)) >= MW'(thr_r);

  assign sh  = SW'(prod_r >>> 16);
  assign tx  = TW'(sh);
  assign tcl = (tx > TPOS) ? TPOS : ((tx < TNEG) ? TNEG : tx);
  assign acc_sat = (acc_r > AMAX) ? AMAX : ((acc_r < AMIN) ? AMIN : acc_r);
  assign emit_last = (op_r.mode == srmam_pkg::MODE_ROW) ||
                     ((EW'(cur_row_r) + EW'(1)) == m_cnt);

  always_comb begin
    ent_rd    = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = row_base + AW'(ek_r);
    ent_wcol  = op_r.col;
    ent_wval  = upd_val;
    cnt_we    = 1'b0;
    cnt_wdata = keep_r;
    vec_we    = 1'b0;
    case (cmd.op)
      srmam_pkg::DP_START: begin
        vec_we = (op_r.mode == srmam_pkg::MODE_VEC) && (EW'(op_r.col) < eff_n);
      end
      srmam_pkg::DP_SCAN: begin
        ent_rd = more && !col_hit;
      end
      srmam_pkg::DP_ADD_UPD: begin
        ent_we = 1'b1;
      end
      srmam_pkg::DP_ADD_NEW: begin
        ent_we    = !full;
        ent_waddr = row_base + AW'(cnt);
        ent_wval  = sat_in;
        cnt_we    = !full;
        cnt_wdata = cnt + KW'(1);
      end
      srmam_pkg::DP_SUM: begin
        ent_rd = more;
      end
      srmam_pkg::DP_PRUNE: begin
        ent_rd    = more;
        ent_we    = ev_r && keep_ok;
        ent_waddr = row_base + AW'(keep_r);
        ent_wcol  = ent_col_q;
        ent_wval  = ent_val_q;
      end
      srmam_pkg::DP_PRN_WB: begin
        cnt_we = 1'b1;
      end
      default: begin
        ent_rd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_col_mem[ent_waddr] <= ent_wcol;
      ent_val_mem[ent_waddr] <= ent_wval;
    end
    if (ent_rd) begin
      ent_col_q <= ent_col_mem[ent_raddr];
      ent_val_q <= ent_val_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cur_row_r] <= cnt_wdata;
    end
    if (cmd.op == srmam_pkg::DP_CNT_RD) begin
      cnt_mem_q <= cnt_mem[cur_row_r];
      cnt_vld_q <= cnt_vld_r[cur_row_r];
    end
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[VAW'(op_r.col)] <= op_r.value;
    end
    if (cmd.op == srmam_pkg::DP_SUM && ev_r) begin
      vec_mem_q <= vec_mem[VAW'(ent_col_q)];
      vec_vld_q <= vec_vld_r[VAW'(ent_col_q)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r   <= '0;
      vec_vld_r   <= '0;
      num_rows_r  <= 7'd64;
      thr_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srmam_pkg::CFG_NUM_ROWS:  num_rows_r <= cfg_wdata[6:0];
          srmam_pkg::CFG_PRUNE_THR: thr_r      <= cfg_wdata;
          default:                  thr_r      <= thr_r;
        endcase
      end
      if (cnt_we) begin
        cnt_vld_r[cur_row_r] <= 1'b1;
      end
      if (vec_we) begin
        vec_vld_r[VAW'(op_r.col)] <= 1'b1;
      end
      if (cmd.op == srmam_pkg::DP_START && op_r.mode == srmam_pkg::MODE_CLEAR) begin
        cnt_vld_r <= '0;
        dropped_r <= 1'b0;
      end
      if (cmd.op == srmam_pkg::DP_ADD_NEW && full) begin
        dropped_r <= 1'b1;
      end
      if (cmd.op == srmam_pkg::DP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      srmam_pkg::DP_LATCH: begin
        op_r <= in_item;
      end
      srmam_pkg::DP_START: begin
        cur_row_r <= (op_r.mode == srmam_pkg::MODE_ADD || op_r.mode == srmam_pkg::MODE_ROW) ?
                     RW'(op_r.row) : '0;
        row_ok_r  <= (op_r.mode != srmam_pkg::MODE_ROW) || (EW'(op_r.row) < eff_n);
      end
      srmam_pkg::DP_CNT_RD: begin
        k_r    <= '0;
        keep_r <= '0;
        ev_r   <= 1'b0;
        pv1_r  <= 1'b0;
        pv2_r  <= 1'b0;
        acc_r  <= '0;
      end
      srmam_pkg::DP_SCAN: begin
        ev_r <= more && !col_hit;
        if (more && !col_hit) begin
          k_r  <= k_r + KW'(1);
          ek_r <= k_r;
        end
      end
      srmam_pkg::DP_SUM: begin
        ev_r  <= more;
        pv1_r <= ev_r;
        pv2_r <= pv1_r;
        if (more) begin
          k_r <= k_r + KW'(1);
        end
        if (ev_r) begin
          val1_r <= ent_val_q;
        end
        if (pv1_r) begin
          prod_r <= PW'(val1_r) * PW'(vec_data);
        end
        if (pv2_r) begin
          acc_r <= acc_r + ACW'(srmam_pkg::TERM_W'(tcl));
        end
      end
      srmam_pkg::DP_PRUNE: begin
        ev_r <= more;
        if (more) begin
          k_r <= k_r + KW'(1);
        end
        if (ev_r && keep_ok) begin
          keep_r <= keep_r + KW'(1);
        end
      end
      srmam_pkg::DP_EMIT: begin
        out_item_r.row_index <= (op_r.mode == srmam_pkg::MODE_ROW) ?
                                op_r.row : srmam_pkg::ROW_W'(cur_row_r);
        out_item_r.sum       <= srmam_pkg::SUM_W'(acc_sat);
        out_item_r.last      <= emit_last;
        out_item_r.overflow  <= dropped_r;
        if (!emit_last) begin
          cur_row_r <= cur_row_r + RW'(1);
        end
      end
      srmam_pkg::DP_PRN_WB: begin
        cur_row_r <= cur_row_r + RW'(1);
      end
      default: begin
        ev_r <= ev_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    sts.mode      = op_r.mode;
    sts.add_ok    = (EW'(op_r.row) < eff_n) && (EW'(op_r.col) < eff_n);
    sts.m_zero    = (m_cnt == '0);
    sts.scan_hit  = col_hit;
    sts.scan_end  = !more && !ev_r;
    sts.sum_done  = !more && !ev_r && !pv1_r && !pv2_r;
    sts.out_free  = !out_valid_r || out_ready;
    sts.emit_last = emit_last;
    sts.prn_last  = (cur_row_r == RW'(ROWS - 1));
  end

endmodule
`default_nettype wire

FILE: rtl/srmam_chk.sv
`default_nettype none
module srmam_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire srmam_pkg::in_item_t  in_item,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire srmam_pkg::out_item_t out_item
);

  a_reset_state: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

endmodule

bind sparse_row_matrix_assemble_multiply srmam_chk u_chk (.*);
`default_nettype wire

FILE: tb/tb_sparse_row_matrix_assemble_multiply.sv
`timescale 1ns / 1ps
module tb_sparse_row_matrix_assemble_multiply;

  localparam int ROWS = 64;
  localparam int EPR = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  srmam_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  srmam_pkg::out_item_t out_item;
  logic cfg_we;
  logic cfg_index;
  logic [30:0] cfg_wdata;

  sparse_row_matrix_assemble_multiply uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  logic [5:0] mat_col [ROWS][EPR];
  longint mat_val [ROWS][EPR];
  int row_len [ROWS];
  longint vec [64];
  bit dropped;
  int active_rows;
  longint thr;

  srmam_pkg::out_item_t sums_pending [$];
  int errors;
  int beats_in;
  int sums_seen;
  longint cycles;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fl16(longint x);
    if (x >= 0) return x / 65536;
    return -((-x + 65535) / 65536);
  endfunction

  function automatic longint dot_row(int r);
    longint acc;
    longint t;
    acc = 0;
    for (int k = 0; k < row_len[r]; k++) begin
      t = fl16(mat_val[r][k] * vec[mat_col[r][k]]);
      if (t > srmam_pkg::TERM_LIM) t = srmam_pkg::TERM_LIM;
      if (t < -srmam_pkg::TERM_LIM) t = -srmam_pkg::TERM_LIM;
      acc += t;
    end
    if (acc > srmam_pkg::SUM_MAX) return srmam_pkg::SUM_MAX;
    if (acc < srmam_pkg::SUM_MIN) return srmam_pkg::SUM_MIN;
    return acc;
  endfunction

  function automatic void push_sum(int r, longint s, bit lst);
    srmam_pkg::out_item_t e;
    e.row_index = r[5:0];
    e.sum = s[47:0];
    e.last = lst;
    e.overflow = dropped;
    sums_pending = {sums_pending, e};
  endfunction

  function automatic void predict(srmam_pkg::in_item_t it);
    int r;
    int c;
    int keep;
    bit hit;
    longint v;
    r = it.row;
    c = it.col;
    v = longint'(it.value);
    case (it.mode)
      srmam_pkg::MODE_ADD: begin
        if (r < active_rows && c < active_rows) begin
          hit = 0;
          for (int k = 0; k < row_len[r]; k++)
            if (!hit && mat_col[r][k] == c) begin
              mat_val[r][k] = sat32(mat_val[r][k] + v);
              hit = 1;
            end
          if (!hit) begin
            if (row_len[r] >= EPR) dropped = 1;
            else begin
              mat_col[r][row_len[r]] = c;
              mat_val[r][row_len[r]] = v;
              row_len[r]++;
            end
          end
        end
      end
      srmam_pkg::MODE_VEC: if (c < active_rows) vec[c] = v;
      srmam_pkg::MODE_MUL_ALL:
        for (int i = 0; i < active_rows; i++) push_sum(i, dot_row(i), i == active_rows - 1);
      srmam_pkg::MODE_ROW: push_sum(r, r < active_rows ? dot_row(r) : 0, 1'b1);
      srmam_pkg::MODE_PRUNE:
        for (int i = 0; i < ROWS; i++) begin
          keep = 0;
          for (int k = 0; k < row_len[i]; k++)
            if ((mat_val[i][k] < 0 ? -mat_val[i][k] : mat_val[i][k]) >= thr) begin
              mat_col[i][keep] = mat_col[i][k];
              mat_val[i][keep] = mat_val[i][k];
              keep++;
            end
          row_len[i] = keep;
        end
      srmam_pkg::MODE_CLEAR: begin
        for (int i = 0; i < ROWS; i++) row_len[i] = 0;
        dropped = 0;
      end
      default: ;
    endcase
  endfunction

  // result checker and output stall generator
  always @(posedge clk) begin
    srmam_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      sums_seen++;
      if (sums_pending.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: expected none actual %p", $time, out_item);
      end else begin
        e = sums_pending.pop_front();
        if (e.row_index !== out_item.row_index || e.sum !== out_item.sum ||
            e.last !== out_item.last || e.overflow !== out_item.overflow) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $time, e, out_item);
        end
      end
    end
  end

  int stall_left;
  always @(negedge clk) begin
    if (quiet || !rst_n) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  task automatic send_beat(logic [2:0] mode, int r, int c, longint v);
    srmam_pkg::in_item_t it;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    it.mode = mode;
    it.row = r[5:0];
    it.col = c[5:0];
    it.value = v[31:0];
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(it);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sums_pending.size() != 0) @(posedge clk);
    repeat (ROWS * 22 + 50) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, longint d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d[30:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == srmam_pkg::CFG_NUM_ROWS) active_rows = (d[6:0] > ROWS) ? ROWS : d[6:0];
    else thr = d[30:0];
  endtask

  function automatic longint rand_val();
    case ($urandom_range(0, 4))
      0: return 64'sd2147483647;
      1: return -64'sd2147483648;
      2: return longint'($signed($urandom_range(0, 32'h3ffff) - 32'h20000));
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  task automatic test_directed();
    send_beat(srmam_pkg::MODE_ROW, 5, 0, 0);
    send_beat(srmam_pkg::MODE_VEC, 0, 0, 64'sd65536);
    send_beat(srmam_pkg::MODE_VEC, 0, 63, -64'sd2147483648);
    send_beat(srmam_pkg::MODE_VEC, 0, 1, 64'sd2147483647);
    send_beat(srmam_pkg::MODE_ADD, 0, 0, 64'sd2147483647);
    send_beat(srmam_pkg::MODE_ADD, 0, 0, 64'sd10);
    send_beat(srmam_pkg::MODE_ADD, 63, 63, -64'sd2147483648);
    send_beat(srmam_pkg::MODE_ADD, 63, 63, -64'sd5);
    send_beat(srmam_pkg::MODE_ADD, 63, 1, 64'sd2147483647);
    for (int k = 0; k < 17; k++) send_beat(srmam_pkg::MODE_ADD, 2, k, 64'sd65536 * k);
    send_beat(srmam_pkg::MODE_ROW, 63, 0, 0);
    send_beat(srmam_pkg::MODE_ROW, 2, 0, 0);
    send_beat(3'd6, 1, 1, 1);
    send_beat(3'd7, 1, 1, 1);
    send_beat(srmam_pkg::MODE_MUL_ALL, 0, 0, 0);
    write_reg(srmam_pkg::CFG_NUM_ROWS, 3);
    send_beat(srmam_pkg::MODE_ADD, 5, 1, 7);
    send_beat(srmam_pkg::MODE_VEC, 0, 10, 7);
    send_beat(srmam_pkg::MODE_ROW, 40, 0, 0);
    send_beat(srmam_pkg::MODE_MUL_ALL, 0, 0, 0);
    write_reg(srmam_pkg::CFG_PRUNE_THR, 64'sd65536 * 5);
    send_beat(srmam_pkg::MODE_PRUNE, 0, 0, 0);
    send_beat(srmam_pkg::MODE_ROW, 2, 0, 0);
    send_beat(srmam_pkg::MODE_CLEAR, 0, 0, 0);
    send_beat(srmam_pkg::MODE_MUL_ALL, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    int m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 99);
      if (m < 50) send_beat(srmam_pkg::MODE_ADD, $urandom_range(0, 63) % (active_rows + 2),
                            $urandom_range(0, 63) % (active_rows + 2), rand_val());
      else if (m < 70)
        send_beat(srmam_pkg::MODE_VEC, $urandom(), $urandom_range(0, 63), rand_val());
      else if (m < 80)
        send_beat(srmam_pkg::MODE_ROW, $urandom_range(0, 63), $urandom(), $urandom());
      else if (m < 86) send_beat(srmam_pkg::MODE_MUL_ALL, $urandom(), $urandom(), $urandom());
      else if (m < 91) send_beat(srmam_pkg::MODE_PRUNE, $urandom(), $urandom(), $urandom());
      else if (m < 94) send_beat(srmam_pkg::MODE_CLEAR, $urandom(), $urandom(), $urandom());
      else send_beat(3'($urandom_range(6, 7)), $urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic test_settings();
    write_reg(srmam_pkg::CFG_NUM_ROWS, 1);
    write_reg(srmam_pkg::CFG_PRUNE_THR, 31'h7fffffff);
    test_random(15);
    write_reg(srmam_pkg::CFG_NUM_ROWS, 8);
    write_reg(srmam_pkg::CFG_PRUNE_THR, $urandom_range(0, 32'h30000));
    test_random(40);
    write_reg(srmam_pkg::CFG_NUM_ROWS, 127);
    write_reg(srmam_pkg::CFG_PRUNE_THR, 0);
    test_random(30);
    write_reg(srmam_pkg::CFG_NUM_ROWS, 64);
    quiet = 1;
    test_random(35);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    cycles = 0;
    errors = 0;
    beats_in = 0;
    sums_seen = 0;
    quiet = 0;
    stall_left = 0;
    dropped = 0;
    active_rows = 64;
    thr = 0;
    for (int i = 0; i < ROWS; i++) row_len[i] = 0;
    for (int i = 0; i < 64; i++) vec[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_settings();
    drain();
    $display("covered %0d commands and %0d row sums over four row counts", beats_in, sums_seen);
    $display("including overflow, saturation, prune and clear");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/srmam_pkg.sv
rtl/srmam_ctrl.sv
rtl/srmam_dp.sv
rtl/sparse_row_matrix_assemble_multiply.sv
rtl/srmam_chk.sv
tb/tb_sparse_row_matrix_assemble_multiply.sv
